@@ design/pdfks_pkg.sv @@
// Shared types, keyword constants and small byte helpers for the PDF keyword scanner.
// No dependencies; imported by every scanner module.
package pdfks_pkg;

	// Width of the internal object, page and /Count counters
	localparam int COUNT_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;
	localparam int WIN_BYTES   = 13;
	localparam int WIN_BITS    = WIN_BYTES * 8;

	// Keyword strings, first character in the most significant byte
	localparam logic [31:0]  KW_JS_SP       = "/JS ";
	localparam logic [31:0]  KW_JS_CR       = {"/JS", 8'h0d};
	localparam logic [31:0]  KW_JS_LF       = "/JS\n";
	localparam logic [31:0]  KW_JS_PAREN    = "/JS(";
	localparam logic [87:0]  KW_JAVASCRIPT  = "/JavaScript";
	localparam logic [87:0]  KW_OPEN_ACTION = "/OpenAction";
	localparam logic [31:0]  KW_AA_SP       = "/AA ";
	localparam logic [31:0]  KW_AA_CR       = {"/AA", 8'h0d};
	localparam logic [31:0]  KW_AA_LF       = "/AA\n";
	localparam logic [31:0]  KW_AA_ANGLE    = "/AA<";
	localparam logic [55:0]  KW_LAUNCH      = "/Launch";
	localparam logic [103:0] KW_EMBEDDED    = "/EmbeddedFile";
	localparam logic [87:0]  KW_SUBMIT      = "/SubmitForm";
	localparam logic [63:0]  KW_ENCRYPT     = "/Encrypt";
	localparam logic [31:0]  KW_OBJ         = " obj";
	localparam logic [39:0]  KW_TYPE        = "/Type";
	localparam logic [47:0]  KW_COUNT       = "/Count";

	// Keyword flag positions
	localparam int FLAG_SCRIPT   = 0;
	localparam int FLAG_OPEN     = 1;
	localparam int FLAG_AA       = 2;
	localparam int FLAG_LAUNCH   = 3;
	localparam int FLAG_EMBEDDED = 4;
	localparam int FLAG_SUBMIT   = 5;
	localparam int FLAG_ENCRYPT  = 6;
	localparam int FLAG_COUNT    = 7;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// One request: a document byte and its end marker
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} req_item_t;

	// One result: the document summary
	typedef struct packed {
		logic        header_valid;
		logic        found_script;
		logic        found_open_action;
		logic        found_additional_action;
		logic        found_launch;
		logic        found_embedded;
		logic        found_submit;
		logic        found_encrypt;
		logic [31:0] object_total;
		logic [31:0] page_total;
	} rsp_item_t;

	// Window matches for the byte just shifted in
	typedef struct packed {
		logic [FLAG_COUNT-1:0] kw;
		logic                  obj;
		logic                  type_key;
		logic                  count_key;
	} hits_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || (b == 8'h0d) || (b == 8'h0a) || (b == 8'h09);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	// Counter value to output width (zero extend or truncate)
	function automatic logic [OUT_WIDTH-1:0] to_out(input count_t v);
		logic [COUNT_WIDTH+OUT_WIDTH-1:0] ext;
		ext = (COUNT_WIDTH + OUT_WIDTH)'(v);
		return ext[OUT_WIDTH-1:0];
	endfunction

endpackage

@@ design/pdfks_window.sv @@
// Thirteen-byte history window and fixed keyword comparators.
// Depends on pdfks_pkg.
module pdfks_window import pdfks_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       last_byte,
	input  logic [7:0] data_byte,
	output hits_t      hits
);

	// Newest byte sits in the low byte
	logic [WIN_BITS-1:0] win_q;
	logic [WIN_BITS-1:0] win_n;

	assign win_n = {win_q[WIN_BITS-9:0], data_byte};

	// Tail comparisons against the updated window
	always_comb begin
		hits = '0;
		hits.kw[FLAG_SCRIPT] = (win_n[31:0] == KW_JS_SP) || (win_n[31:0] == KW_JS_CR) ||
			(win_n[31:0] == KW_JS_LF) || (win_n[31:0] == KW_JS_PAREN) ||
			(win_n[87:0] == KW_JAVASCRIPT);
		hits.kw[FLAG_OPEN] = (win_n[87:0] == KW_OPEN_ACTION);
		hits.kw[FLAG_AA] = (win_n[31:0] == KW_AA_SP) || (win_n[31:0] == KW_AA_CR) ||
			(win_n[31:0] == KW_AA_LF) || (win_n[31:0] == KW_AA_ANGLE);
		hits.kw[FLAG_LAUNCH]   = (win_n[55:0] == KW_LAUNCH);
		hits.kw[FLAG_EMBEDDED] = (win_n[103:0] == KW_EMBEDDED);
		hits.kw[FLAG_SUBMIT]   = (win_n[87:0] == KW_SUBMIT);
		hits.kw[FLAG_ENCRYPT]  = (win_n[63:0] == KW_ENCRYPT);
		hits.obj       = is_digit(win_n[39:32]) && (win_n[31:0] == KW_OBJ);
		hits.type_key  = (win_n[39:0] == KW_TYPE);
		hits.count_key = (win_n[47:0] == KW_COUNT);
	end

	// Window shifts on every byte, clears after the document ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (step) begin
			win_q <= last_byte ? '0 : win_n;
		end
	end

endmodule

@@ design/pdfks_tally.sv @@
// Header check, sticky flags, object/page counters and /Count number tracking.
// Depends on pdfks_pkg; produces the summary for the byte being processed.
module pdfks_tally import pdfks_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       last_byte,
	input  logic [7:0] data_byte,
	input  hits_t      hits,
	output rsp_item_t  summary
);

	typedef enum logic [2:0] {
		TT_IDLE, TT_WS, TT_P, TT_A, TT_G, TT_E, TT_DONE
	} type_state_t;

	typedef enum logic [1:0] {
		NT_IDLE, NT_WS, NT_DIGITS
	} num_state_t;

	localparam count_t CNT_MAX = '1;

	logic [2:0]            pos_q, pos_n;
	logic                  hdr_q, hdr_n;
	logic [FLAG_COUNT-1:0] flags_q, flags_n;
	count_t                obj_q, obj_n;
	count_t                page_q, page_n;
	type_state_t           tt_q, tt_n;
	num_state_t            nt_q, nt_n;
	count_t                acc_q, acc_n;
	count_t                big_q, big_n;

	logic [7:0]             hdr_char;
	logic [7:0]             page_char;
	logic [COUNT_WIDTH+3:0] acc10;
	count_t                 pages;
	logic                   valid;

	// Expected header byte at each position
	always_comb begin
		case (pos_q)
			3'd0:    hdr_char = "%";
			3'd1:    hdr_char = "P";
			3'd2:    hdr_char = "D";
			3'd3:    hdr_char = "F";
			default: hdr_char = 8'h00;
		endcase
	end

	// Expected byte of "/Page" for each tracker state
	always_comb begin
		case (tt_q)
			TT_WS:   page_char = "/";
			TT_P:    page_char = "P";
			TT_A:    page_char = "a";
			TT_G:    page_char = "g";
			TT_E:    page_char = "e";
			default: page_char = 8'h00;
		endcase
	end

	// acc * 10 + digit, with headroom to spot overflow
	assign acc10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
		(COUNT_WIDTH + 4)'(data_byte[3:0]);

	// Next-state logic for one byte
	always_comb begin
		pos_n   = pos_q;
		hdr_n   = hdr_q;
		flags_n = flags_q | hits.kw;
		obj_n   = obj_q;
		page_n  = page_q;
		tt_n    = tt_q;
		nt_n    = nt_q;
		acc_n   = acc_q;
		big_n   = big_q;

		if (pos_q < 3'd4 && data_byte != hdr_char)
			hdr_n = 1'b0;
		if (pos_q < 3'd5)
			pos_n = pos_q + 3'd1;

		if (hits.obj && obj_q != CNT_MAX)
			obj_n = obj_q + 1'b1;

		// /Type /Page tracker
		if (tt_q == TT_DONE) begin
			if (data_byte != "s" && page_q != CNT_MAX)
				page_n = page_q + 1'b1;
			tt_n = TT_IDLE;
		end else if (tt_q == TT_WS && is_ws(data_byte)) begin
			tt_n = TT_WS;
		end else if (tt_q != TT_IDLE) begin
			if (data_byte == page_char) begin
				tt_n = type_state_t'(tt_q + 3'd1);
				if (tt_q == TT_E && last_byte) begin
					if (page_q != CNT_MAX)
						page_n = page_q + 1'b1;
					tt_n = TT_IDLE;
				end
			end else begin
				tt_n = TT_IDLE;
			end
		end
		if (hits.type_key)
			tt_n = TT_WS;

		// /Count number tracker
		case (nt_q)
			NT_WS: begin
				if (is_digit(data_byte)) begin
					acc_n = count_t'(data_byte[3:0]);
					nt_n  = NT_DIGITS;
				end else if (!is_ws(data_byte)) begin
					nt_n = NT_IDLE;
				end
			end
			NT_DIGITS: begin
				if (is_digit(data_byte)) begin
					if (acc10[COUNT_WIDTH+3:COUNT_WIDTH] != 4'd0)
						acc_n = CNT_MAX;
					else
						acc_n = acc10[COUNT_WIDTH-1:0];
				end else begin
					if (acc_q > big_q)
						big_n = acc_q;
					nt_n = NT_IDLE;
				end
			end
			default: nt_n = NT_IDLE;
		endcase
		if (hits.count_key) begin
			nt_n  = NT_WS;
			acc_n = '0;
		end
		if (last_byte && nt_n == NT_DIGITS) begin
			if (acc_n > big_n)
				big_n = acc_n;
			nt_n = NT_IDLE;
		end
	end

	// Summary from the updated state
	assign valid = hdr_n && (pos_n >= 3'd5);
	assign pages = (page_n != '0) ? page_n : big_n;

	always_comb begin
		summary = '0;
		if (valid) begin
			summary.header_valid            = 1'b1;
			summary.found_script            = flags_n[FLAG_SCRIPT];
			summary.found_open_action       = flags_n[FLAG_OPEN];
			summary.found_additional_action = flags_n[FLAG_AA];
			summary.found_launch            = flags_n[FLAG_LAUNCH];
			summary.found_embedded          = flags_n[FLAG_EMBEDDED];
			summary.found_submit            = flags_n[FLAG_SUBMIT];
			summary.found_encrypt           = flags_n[FLAG_ENCRYPT];
			summary.object_total            = to_out(obj_n);
			summary.page_total              = to_out(pages);
		end
	end

	// State registers; the end of a document returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hdr_q   <= 1'b1;
			flags_q <= '0;
			obj_q   <= '0;
			page_q  <= '0;
			tt_q    <= TT_IDLE;
			nt_q    <= NT_IDLE;
			acc_q   <= '0;
			big_q   <= '0;
		end else if (step) begin
			if (last_byte) begin
				pos_q   <= '0;
				hdr_q   <= 1'b1;
				flags_q <= '0;
				obj_q   <= '0;
				page_q  <= '0;
				tt_q    <= TT_IDLE;
				nt_q    <= NT_IDLE;
				acc_q   <= '0;
				big_q   <= '0;
			end else begin
				pos_q   <= pos_n;
				hdr_q   <= hdr_n;
				flags_q <= flags_n;
				obj_q   <= obj_n;
				page_q  <= page_n;
				tt_q    <= tt_n;
				nt_q    <= nt_n;
				acc_q   <= acc_n;
				big_q   <= big_n;
			end
		end
	end

endmodule

@@ design/pdf_keyword_scanner.sv @@
// PDF keyword scanner top level: input register, window/tally logic, result register.
// The summary is registered as the last_byte request steps out of the input register.
// Throughput: one byte per cycle; a waiting summary only stalls a following last byte.
// Each byte makes a single pass through window compare and tally update.
// Reset (arst_n low, asynchronous) empties both registers and clears all scan state.
module pdf_keyword_scanner import pdfks_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	logic      valid_s1;
	req_item_t req_s1;
	logic      step;
	hits_t     hits;
	rsp_item_t summary;
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	// A byte moves on unless it ends a document and the result slot is full and not being read
	assign step      = valid_s1 && (!req_s1.last_byte || !rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= req;
	end

	pdfks_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.last_byte (req_s1.last_byte),
		.data_byte (req_s1.data_byte),
		.hits      (hits)
	);

	pdfks_tally u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.last_byte (req_s1.last_byte),
		.data_byte (req_s1.data_byte),
		.hits      (hits),
		.summary   (summary)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step && req_s1.last_byte) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && req_s1.last_byte)
			rsp_q <= summary;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
